>>> rtl/bounded_plurality_vote_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the plurality vote classifier core
// Shared concurrent assertion forms, all sampled on the rising clock edge
// and disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PLURALITY_VOTE_CLASSIFIER_CORE_MACROS_SVH
`define BOUNDED_PLURALITY_VOTE_CLASSIFIER_CORE_MACROS_SVH

// Condition holds at every edge.
`define BPVC_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BPVC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BPVC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_pkg
// Shared constants, word types and state encodings of the vote classifier.
// ----------------------------------------------------------------------------
package bpvc_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int COUNT_BITS    = 16;
  localparam int LABEL_BITS    = 32;
  localparam int HITS_OUT_BITS = 16;
  localparam int CONF_BITS     = 17;

  localparam int ENTRY_BITS    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS     = CONF_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CONF_BITS-1:0]  CONF_ONE  = CONF_BITS'(65536);

  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic                  has_label;
    logic                  last_of_read;
  } in_word_t;

  typedef struct packed {
    logic [LABEL_BITS-1:0]    best_label;
    logic [HITS_OUT_BITS-1:0] best_hits;
    logic [CONF_BITS-1:0]     confidence;
  } out_word_t;

  // Classified word between the front end and the tally engine.
  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic                  counts;  // adds to the read length
    logic                  vote;    // goes to the tally table
    logic                  last;    // closes the read
  } q_word_t;

  // Snapshot of a closed read handed to the divider.
  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic [COUNT_BITS-1:0] hits;
    logic [COUNT_BITS-1:0] length;
    logic                  found;
  } div_req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_UPDATE,
    B_CLOSE
  } back_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

endpackage

>>> rtl/bounded_plurality_vote_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_plurality_vote_classifier_core
// Plurality vote over the class labels of one read with a bounded tally.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake              word
//   in_*         in    in_valid / in_ready    bpvc_pkg::in_word_t
//   out_*        out   out_valid / out_ready  bpvc_pkg::out_word_t
//
// Flow: the front end takes one word per cycle, unless the queue backs up,
//   into a four-word queue. The tally engine compares and pops a voting word
//   in B_IDLE and does the hit update and lead check in B_UPDATE, takes any
//   other word in B_IDLE alone, and hands a closed read on from B_CLOSE.
// The confidence divider retires one quotient bit a cycle in D_RUN: it takes
//   the request in D_IDLE, forms the 17 quotient bits in D_RUN and loads the
//   result register from D_DONE, overlapped with the next read's tally work.
// Reset: rst_n is synchronous, active low; no clearing pass is needed since
//   table entries at or above the fill count read as empty.
// Stalls: out_ready low holds the result register; the divider, then the
//   tally engine, then the queue and finally in_ready back up in turn.
//
module bounded_plurality_vote_classifier_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpvc_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bpvc_pkg::out_word_t out_data
);

  // Front end to queue.
  logic               fq_valid;
  logic               fq_ready;
  bpvc_pkg::q_word_t  fq_data;

  // Queue to tally engine.
  logic               qt_valid;
  logic               qt_ready;
  bpvc_pkg::q_word_t  qt_data;

  // Tally engine to divider: one word per closed read.
  logic               td_valid;
  logic               td_ready;
  bpvc_pkg::div_req_t td_req;

  // Classify incoming words and drop those without effect.
  bpvc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // Decouple the front end from the tally engine.
  bpvc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qt_valid),
    .pop_ready  (qt_ready),
    .pop_data   (qt_data)
  );

  // Count hits, track the leading entry, close reads.
  bpvc_tally u_tally (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (qt_valid),
    .q_ready       (qt_ready),
    .q_data        (qt_data),
    .div_req_valid (td_valid),
    .div_req_ready (td_ready),
    .div_req       (td_req)
  );

  // Compute hits * 2^16 / length and drive the result register.
  bpvc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (td_valid),
    .req_ready (td_ready),
    .req       (td_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/bpvc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpvc_front
// Accept input words, classify them and drop words that have no effect.
// ----------------------------------------------------------------------------
module bpvc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bpvc_pkg::in_word_t  in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output bpvc_pkg::q_word_t   q_data
);

  logic               stg_valid_r, stg_valid_nxt;
  bpvc_pkg::q_word_t  stg_data_r, stg_data_nxt;
  logic               accept;
  logic               keep;

  assign in_ready = !stg_valid_r || q_ready;
  assign accept   = in_valid && in_ready;
  // A word without a label that does not close the read changes nothing.
  assign keep     = in_data.has_label || in_data.last_of_read;

  always_comb begin
    stg_valid_nxt = stg_valid_r && !q_ready;
    stg_data_nxt  = stg_data_r;
    if (accept) begin
      stg_valid_nxt       = keep;
      stg_data_nxt.label  = in_data.label;
      stg_data_nxt.counts = in_data.has_label;
      stg_data_nxt.vote   = in_data.has_label && (in_data.label != '0);
      stg_data_nxt.last   = in_data.last_of_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stg_data_r <= stg_data_nxt;
  end

  assign q_valid = stg_valid_r;
  assign q_data  = stg_data_r;

endmodule

>>> rtl/bpvc_fifo.sv
`timescale 1ns / 1ps
`include "bounded_plurality_vote_classifier_core_macros.svh"
// ----------------------------------------------------------------------------
// bpvc_fifo
// Short show-ahead queue between the front end and the tally engine.
// ----------------------------------------------------------------------------
module bpvc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  bpvc_pkg::q_word_t  push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bpvc_pkg::q_word_t  pop_data
);

  bpvc_pkg::q_word_t                mem_r [bpvc_pkg::QUEUE_DEPTH];
  logic [bpvc_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [bpvc_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [bpvc_pkg::QCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (cnt_r != bpvc_pkg::QCNT_BITS'(bpvc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bpvc_pkg::QPTR_BITS'(bpvc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + bpvc_pkg::QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bpvc_pkg::QPTR_BITS'(bpvc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + bpvc_pkg::QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + bpvc_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - bpvc_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `BPVC_ASSERT_ALWAYS(a_fifo_cnt_bound, clk, rst_n, cnt_r <= bpvc_pkg::QCNT_BITS'(bpvc_pkg::QUEUE_DEPTH), "queue fill count exceeds depth")

endmodule

>>> rtl/bpvc_tally.sv
`timescale 1ns / 1ps
`include "bounded_plurality_vote_classifier_core_macros.svh"
// ----------------------------------------------------------------------------
// bpvc_tally
// Tally engine: match labels against the table, count hits, track the lead.
// ----------------------------------------------------------------------------
module bpvc_tally (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  bpvc_pkg::q_word_t  q_data,
  output logic               div_req_valid,
  input  logic               div_req_ready,
  output bpvc_pkg::div_req_t div_req
);

  localparam int N  = bpvc_pkg::TABLE_ENTRIES;
  localparam int EB = bpvc_pkg::ENTRY_BITS;
  localparam int UB = bpvc_pkg::USED_BITS;
  localparam int CB = bpvc_pkg::COUNT_BITS;
  localparam int LB = bpvc_pkg::LABEL_BITS;

  bpvc_pkg::back_state_t state_r, state_nxt;

  logic [LB-1:0] labels_r [N];
  logic [CB-1:0] hits_r   [N];

  logic [UB-1:0] used_r, used_nxt;
  logic [CB-1:0] len_r, len_nxt;
  logic [CB-1:0] lead_hits_r, lead_hits_nxt;
  logic [EB-1:0] lead_entry_r, lead_entry_nxt;
  logic [LB-1:0] lead_label_r, lead_label_nxt;
  logic [LB-1:0] cur_label_r, cur_label_nxt;
  logic          cur_last_r, cur_last_nxt;
  logic [EB-1:0] slot_r, slot_nxt;
  logic          hit_r, hit_nxt;

  logic          pop;
  logic          close_done;
  logic [N-1:0]  match;
  logic          found;
  logic [EB-1:0] found_idx;
  logic          room;
  logic          do_write;
  logic [CB-1:0] new_hits;
  logic          take_lead;

  // Parallel tag compare over the entries in use; lowest index wins.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < N; j++) begin
      match[j] = (UB'(j) < used_r) && (labels_r[j] == q_data.label);
    end
    for (int j = N - 1; j >= 0; j--) begin
      if (match[j]) begin
        found     = 1'b1;
        found_idx = EB'(j);
      end
    end
  end

  assign room      = (used_r < UB'(N));
  assign do_write  = (state_r == bpvc_pkg::B_UPDATE) && (hit_r || room);
  assign new_hits  = hit_r ? bpvc_pkg::sat_inc(hits_r[slot_r]) : CB'(1);
  assign take_lead = (new_hits > lead_hits_r) ||
                     ((new_hits == lead_hits_r) && (slot_r < lead_entry_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpvc_pkg::B_IDLE: begin
        if (q_valid) begin
          if (q_data.vote) begin
            state_nxt = bpvc_pkg::B_UPDATE;
          end else if (q_data.last) begin
            state_nxt = bpvc_pkg::B_CLOSE;
          end
        end
      end
      bpvc_pkg::B_UPDATE: begin
        state_nxt = cur_last_r ? bpvc_pkg::B_CLOSE : bpvc_pkg::B_IDLE;
      end
      bpvc_pkg::B_CLOSE: begin
        if (div_req_ready) begin
          state_nxt = bpvc_pkg::B_IDLE;
        end
      end
      default: state_nxt = bpvc_pkg::B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_ready       = 1'b0;
    div_req_valid = 1'b0;
    unique case (state_r)
      bpvc_pkg::B_IDLE:   q_ready = 1'b1;
      bpvc_pkg::B_UPDATE: q_ready = 1'b0;
      bpvc_pkg::B_CLOSE:  div_req_valid = 1'b1;
      default: begin
        q_ready       = 1'b0;
        div_req_valid = 1'b0;
      end
    endcase
  end

  assign pop        = q_valid && q_ready;
  assign close_done = div_req_valid && div_req_ready;

  assign div_req.label  = lead_label_r;
  assign div_req.hits   = lead_hits_r;
  assign div_req.length = len_r;
  assign div_req.found  = (used_r != '0);

  // Datapath next values.
  always_comb begin
    used_nxt       = used_r;
    len_nxt        = len_r;
    lead_hits_nxt  = lead_hits_r;
    lead_entry_nxt = lead_entry_r;
    lead_label_nxt = lead_label_r;
    cur_label_nxt  = cur_label_r;
    cur_last_nxt   = cur_last_r;
    slot_nxt       = slot_r;
    hit_nxt        = hit_r;
    if (pop) begin
      if (q_data.counts) begin
        len_nxt = bpvc_pkg::sat_inc(len_r);
      end
      cur_label_nxt = q_data.label;
      cur_last_nxt  = q_data.last;
      hit_nxt       = found;
      slot_nxt      = found ? found_idx : used_r[EB-1:0];
    end
    if (do_write) begin
      if (!hit_r) begin
        used_nxt = used_r + UB'(1);
      end
      if (take_lead) begin
        lead_hits_nxt  = new_hits;
        lead_entry_nxt = slot_r;
        lead_label_nxt = cur_label_r;
      end
    end
    // Clear the tally once the closed read is handed off.
    if (close_done) begin
      used_nxt       = '0;
      len_nxt        = '0;
      lead_hits_nxt  = '0;
      lead_entry_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bpvc_pkg::B_IDLE;
      used_r       <= '0;
      len_r        <= '0;
      lead_hits_r  <= '0;
      lead_entry_r <= '0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      len_r        <= len_nxt;
      lead_hits_r  <= lead_hits_nxt;
      lead_entry_r <= lead_entry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_label_r <= lead_label_nxt;
    cur_label_r  <= cur_label_nxt;
    cur_last_r   <= cur_last_nxt;
    slot_r       <= slot_nxt;
    hit_r        <= hit_nxt;
  end

  // Entries at or above used_r read as empty, so hit counts need no clearing.
  always_ff @(posedge clk) begin
    if (do_write) begin
      hits_r[slot_r] <= new_hits;
      if (!hit_r) begin
        labels_r[slot_r] <= cur_label_r;
      end
    end
  end

  `BPVC_ASSERT_ALWAYS(a_used_bound, clk, rst_n, used_r <= UB'(N), "tally table overfilled")
  `BPVC_ASSERT_ALWAYS(a_lead_le_len, clk, rst_n, lead_hits_r <= len_r, "lead hits exceed read length")
  `BPVC_ASSERT_NEXT(a_close_clears, clk, rst_n, close_done, (used_r == '0) && (len_r == '0) && (lead_hits_r == '0), "tally not cleared after read")

endmodule

>>> rtl/bpvc_div.sv
`timescale 1ns / 1ps
`include "bounded_plurality_vote_classifier_core_macros.svh"
// ----------------------------------------------------------------------------
// bpvc_div
// Radix-2 restoring divider for the confidence, plus the output register.
// ----------------------------------------------------------------------------
module bpvc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  bpvc_pkg::div_req_t  req,
  output logic                out_valid,
  input  logic                out_ready,
  output bpvc_pkg::out_word_t out_data
);

  localparam int CB = bpvc_pkg::COUNT_BITS;
  localparam int QB = bpvc_pkg::CONF_BITS;
  localparam int HB = bpvc_pkg::HITS_OUT_BITS;
  localparam int KB = bpvc_pkg::DIV_CNT_BITS;

  bpvc_pkg::div_state_t state_r, state_nxt;

  logic [CB:0]                     rem_r, rem_nxt;
  logic [CB-1:0]                   den_r, den_nxt;
  logic [QB-1:0]                   quot_r, quot_nxt;
  logic [KB-1:0]                   cnt_r, cnt_nxt;
  logic [bpvc_pkg::LABEL_BITS-1:0] label_r, label_nxt;
  logic [CB-1:0]                   hits_r, hits_nxt;
  logic                            found_r, found_nxt;

  logic                            out_valid_r, out_valid_nxt;
  bpvc_pkg::out_word_t             out_data_r, out_data_nxt;

  logic                            ge;
  logic [CB:0]                     diff;
  logic [CB+HB-1:0]                hits_wide;
  logic                            last_step;
  logic                            load_out;

  assign ge        = (rem_r >= {1'b0, den_r});
  assign diff      = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  assign last_step = (cnt_r == KB'(bpvc_pkg::DIV_STEPS - 1));
  assign hits_wide = {{HB{1'b0}}, hits_r};
  assign load_out  = (state_r == bpvc_pkg::D_DONE) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpvc_pkg::D_IDLE: if (req_valid) state_nxt = bpvc_pkg::D_RUN;
      bpvc_pkg::D_RUN:  if (last_step) state_nxt = bpvc_pkg::D_DONE;
      bpvc_pkg::D_DONE: if (load_out)  state_nxt = bpvc_pkg::D_IDLE;
      default:          state_nxt = bpvc_pkg::D_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req_ready = 1'b0;
    unique case (state_r)
      bpvc_pkg::D_IDLE: req_ready = 1'b1;
      bpvc_pkg::D_RUN:  req_ready = 1'b0;
      bpvc_pkg::D_DONE: req_ready = 1'b0;
      default:          req_ready = 1'b0;
    endcase
  end

  // Datapath: one quotient bit per cycle, most significant first.
  always_comb begin
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    label_nxt     = label_r;
    hits_nxt      = hits_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if ((state_r == bpvc_pkg::D_IDLE) && req_valid) begin
      rem_nxt   = {1'b0, req.hits};
      den_nxt   = req.length;
      quot_nxt  = '0;
      cnt_nxt   = '0;
      label_nxt = req.label;
      hits_nxt  = req.hits;
      found_nxt = req.found;
    end
    if (state_r == bpvc_pkg::D_RUN) begin
      rem_nxt  = {diff[CB-1:0], 1'b0};
      quot_nxt = {quot_r[QB-2:0], ge};
      cnt_nxt  = cnt_r + KB'(1);
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      if (found_r) begin
        out_data_nxt.best_label = label_r;
        out_data_nxt.best_hits  = hits_wide[HB-1:0];
        out_data_nxt.confidence = quot_r;
      end else begin
        out_data_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpvc_pkg::D_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    label_r    <= label_nxt;
    hits_r     <= hits_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BPVC_ASSERT_IMPL(a_conf_le_one, clk, rst_n, (state_r == bpvc_pkg::D_DONE) && found_r, quot_r <= bpvc_pkg::CONF_ONE, "confidence above one")

endmodule
